// File: rtl/jsr_pkg.sv
// Shared constants, register map and controller/datapath interface types
// for the joystick smoothing reporter. No dependencies.

package jsr_pkg;

	localparam int unsigned DEF_WINDOW_DEPTH = 5;
	localparam int unsigned DEF_SAMPLE_BITS  = 10;
	localparam int unsigned FRAC_BITS        = 8;

	localparam int unsigned TIME_BITS   = 32;
	localparam int unsigned DEB_BITS    = 16;
	localparam int unsigned THR_BITS    = 10;
	localparam int unsigned APB_DATA_W  = 32;
	localparam int unsigned APB_ADDR_W  = 4;

	localparam logic [TIME_BITS-1:0] PERIOD_RST    = 32'd100;
	localparam logic [DEB_BITS-1:0]  DEBOUNCE_RST  = 16'd50;
	localparam logic [THR_BITS-1:0]  THRESHOLD_RST = 10'd10;

	typedef enum logic [1:0] {
		REG_PERIOD    = 2'd0,
		REG_DEBOUNCE  = 2'd1,
		REG_THRESHOLD = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_idx_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;       // capture the input beat
		logic apply;      // poll acts: timers, debounce, ring write
		logic sum_start;  // clear sums and step counter
		logic sum_step;   // add one ring entry
		logic div_start;  // load dividers from the sums
		logic div_step;   // one quotient bit
		logic emit;       // load output register, update reported means
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic poll_ok;
		logic sum_last;
		logic div_last;
		logic report;
		logic out_free;
	} ctrl_sts_t;

endpackage

// File: rtl/jsr_ctrl.sv
// Sequencing state machine for the joystick smoothing reporter.
// Depends on jsr_pkg for the command and status structs.

module jsr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jsr_pkg::ctrl_sts_t sts,
	output jsr_pkg::ctrl_cmd_t cmd
);
	import jsr_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CHECK  = 6'b000010,
		ST_SUM    = 6'b000100,
		ST_PREP   = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_DECIDE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.poll_ok) begin
					cmd.apply     = 1'b1;
					cmd.sum_start = 1'b1;
					state_d       = ST_SUM;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.sum_last)
					state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				// hold here while the previous result beat is still pending
				if (!sts.report) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (sts.report && sts.out_free))
		else $error("result emitted without report or free output slot");

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.div_last) |=> (state_q == ST_DIV))
		else $error("divider left before its last step");

	a_load_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_CHECK && !in_ready))
		else $error("accepted beat not followed by period check");
`endif

endmodule

// File: rtl/jsr_dp.sv
// Datapath: poll timing, button debounce, sample rings, serial averaging
// dividers, report decision and output register. Depends on jsr_pkg.

module jsr_dp #(
	parameter int unsigned WINDOW_DEPTH = jsr_pkg::DEF_WINDOW_DEPTH,
	parameter int unsigned SAMPLE_BITS  = jsr_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  jsr_pkg::ctrl_cmd_t                  cmd,
	output jsr_pkg::ctrl_sts_t                  sts,
	input  logic [jsr_pkg::TIME_BITS-1:0]       in_now,
	input  logic [SAMPLE_BITS-1:0]              in_x,
	input  logic [SAMPLE_BITS-1:0]              in_y,
	input  logic                                in_button,
	input  logic [jsr_pkg::TIME_BITS-1:0]       period_ms,
	input  logic [jsr_pkg::DEB_BITS-1:0]        debounce_ms,
	input  logic [jsr_pkg::THR_BITS-1:0]        change_threshold,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [SAMPLE_BITS+jsr_pkg::FRAC_BITS-1:0] out_mean_x,
	output logic [SAMPLE_BITS+jsr_pkg::FRAC_BITS-1:0] out_mean_y,
	output logic                                out_pressed
);
	import jsr_pkg::*;

	localparam int unsigned MEAN_W = SAMPLE_BITS + FRAC_BITS;
	localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
	localparam int unsigned DIV_W  = SUM_W + FRAC_BITS;
	localparam int unsigned STEP_W = $clog2(DIV_W);
	localparam int unsigned CMP_W  = (STEP_W > CNT_W) ? STEP_W : CNT_W;
	localparam int unsigned LIM_W  = (MEAN_W > THR_BITS + FRAC_BITS) ?
		MEAN_W : THR_BITS + FRAC_BITS;
	localparam int unsigned AXES   = 2;

	// captured beat
	logic [TIME_BITS-1:0]   now_q;
	logic [SAMPLE_BITS-1:0] smp_q [AXES];
	logic                   raw_q;

	// persistent state
	logic [TIME_BITS-1:0]   last_poll_q;
	logic [TIME_BITS-1:0]   last_chg_q;
	logic                   prev_raw_q;
	logic                   stable_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [CNT_W-1:0]       fill_q;
	logic [MEAN_W-1:0]      rep_q [AXES];
	logic                   rep_any_q;
	logic [SAMPLE_BITS-1:0] ring_q [AXES][WINDOW_DEPTH];

	// working registers
	logic [STEP_W-1:0]      step_q;
	logic [SUM_W-1:0]       sum_q [AXES];
	logic [DIV_W-1:0]       dvd_q [AXES];
	logic [CNT_W-1:0]       rem_q [AXES];

	// output register
	logic                   out_valid_q;
	logic [MEAN_W-1:0]      out_mean_q [AXES];
	logic                   out_pressed_q;

	logic [TIME_BITS-1:0]   chg_time;
	logic [TIME_BITS-1:0]   held_ms;
	logic                   step_in_fill;
	logic [CNT_W:0]         trial [AXES];
	logic                   ge [AXES];
	logic [MEAN_W-1:0]      mean [AXES];
	logic [MEAN_W-1:0]      diff [AXES];
	logic                   moved [AXES];
	logic [LIM_W-1:0]       limit;

	assign chg_time     = (raw_q != prev_raw_q) ? now_q : last_chg_q;
	assign held_ms      = now_q - chg_time;
	assign step_in_fill = CMP_W'(step_q) < CMP_W'(fill_q);
	assign limit        = LIM_W'({change_threshold, {FRAC_BITS{1'b0}}});

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			trial[a] = {rem_q[a], dvd_q[a][DIV_W-1]};
			ge[a]    = trial[a] >= {1'b0, fill_q};
			mean[a]  = dvd_q[a][MEAN_W-1:0];
			diff[a]  = (mean[a] >= rep_q[a]) ? (mean[a] - rep_q[a]) : (rep_q[a] - mean[a]);
			moved[a] = LIM_W'(diff[a]) > limit;
		end
	end

	assign sts.poll_ok  = (now_q - last_poll_q) >= period_ms;
	assign sts.sum_last = (step_q == STEP_W'(WINDOW_DEPTH - 1));
	assign sts.div_last = (step_q == STEP_W'(DIV_W - 1));
	assign sts.report   = !rep_any_q || moved[0] || moved[1] || stable_q;
	assign sts.out_free = !out_valid_q || out_ready;

	// input capture, ring storage, arithmetic and output data registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q    <= in_now;
			smp_q[0] <= in_x;
			smp_q[1] <= in_y;
			raw_q    <= in_button;
		end
		for (int a = 0; a < AXES; a++) begin
			if (cmd.apply)
				ring_q[a][slot_q] <= smp_q[a];
			if (cmd.sum_start)
				sum_q[a] <= '0;
			else if (cmd.sum_step && step_in_fill)
				sum_q[a] <= sum_q[a] + SUM_W'(ring_q[a][step_q[SLOT_W-1:0]]);
			if (cmd.div_start) begin
				dvd_q[a] <= {sum_q[a], {FRAC_BITS{1'b0}}};
				rem_q[a] <= '0;
			end else if (cmd.div_step) begin
				// restoring division, one quotient bit per cycle
				dvd_q[a] <= {dvd_q[a][DIV_W-2:0], ge[a]};
				rem_q[a] <= ge[a] ? CNT_W'(trial[a] - {1'b0, fill_q}) : trial[a][CNT_W-1:0];
			end
			if (cmd.emit)
				out_mean_q[a] <= mean[a];
		end
		if (cmd.emit)
			out_pressed_q <= stable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_poll_q <= '0;
			last_chg_q  <= '0;
			prev_raw_q  <= 1'b0;
			stable_q    <= 1'b0;
			slot_q      <= '0;
			fill_q      <= '0;
			rep_q[0]    <= '0;
			rep_q[1]    <= '0;
			rep_any_q   <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply) begin
				last_poll_q <= now_q;
				last_chg_q  <= chg_time;
				if (held_ms > TIME_BITS'(debounce_ms))
					stable_q <= raw_q;
				prev_raw_q  <= raw_q;
				slot_q      <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
				if (fill_q < CNT_W'(WINDOW_DEPTH))
					fill_q <= fill_q + 1'b1;
			end
			if (cmd.sum_start || cmd.div_start)
				step_q <= '0;
			else if (cmd.sum_step || cmd.div_step)
				step_q <= step_q + 1'b1;
			if (cmd.emit) begin
				rep_q[0]    <= mean[0];
				rep_q[1]    <= mean[1];
				rep_any_q   <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_mean_x  = out_mean_q[0];
	assign out_mean_y  = out_mean_q[1];
	assign out_pressed = out_pressed_q;

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> (fill_q != '0 && fill_q <= CNT_W'(WINDOW_DEPTH)))
		else $error("fill count out of range after ring write");

	a_emit_sets_any: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (rep_any_q && out_valid_q))
		else $error("emit did not mark a report");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result beat dropped before it was taken");
`endif

endmodule

// File: rtl/joystick_smoothing_reporter_unit.sv
// A poll that does not act goes from the period check back to idle. An acting poll
// writes the ring, sums it serially and divides bit-serially (DIV_W = SAMPLE_BITS +
// clog2(WINDOW_DEPTH) + 8); if a report is due it waits for a free output slot and
// loads the output register, where one result beat may wait. No new poll is taken
// until the last is done. Reset: arst_n clears control and tracking state but not the
// ring or data registers; registers return to 100 / 50 / 10.

module joystick_smoothing_reporter_unit #(
	parameter int unsigned WINDOW_DEPTH = jsr_pkg::DEF_WINDOW_DEPTH,
	parameter int unsigned SAMPLE_BITS  = jsr_pkg::DEF_SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	// now_ms[31:0], x_sample, y_sample, button_raw, zero pad
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((33+2*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
	// mean_x, mean_y, pressed, zero pad
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [((2*(SAMPLE_BITS+jsr_pkg::FRAC_BITS)+1+7)/8)*8-1:0] m_tdata,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [jsr_pkg::APB_ADDR_W-1:0]          paddr,
	input  logic [jsr_pkg::APB_DATA_W-1:0]          pwdata,
	output logic [jsr_pkg::APB_DATA_W-1:0]          prdata,
	output logic                                    pready
);
	import jsr_pkg::*;

	localparam int unsigned MEAN_W  = SAMPLE_BITS + FRAC_BITS;
	localparam int unsigned IN_USED = TIME_BITS + 2 * SAMPLE_BITS + 1;
	localparam int unsigned OUT_USED = 2 * MEAN_W + 1;
	localparam int unsigned OUT_W    = ((OUT_USED + 7) / 8) * 8;

	logic [TIME_BITS-1:0] period_q;
	logic [DEB_BITS-1:0]  debounce_q;
	logic [THR_BITS-1:0]  threshold_q;
	reg_idx_t             reg_sel;
	logic                 cfg_wr;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	logic [MEAN_W-1:0] mean_x;
	logic [MEAN_W-1:0] mean_y;
	logic              pressed;

	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RST;
			debounce_q  <= DEBOUNCE_RST;
			threshold_q <= THRESHOLD_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_PERIOD:    period_q    <= pwdata;
				REG_DEBOUNCE:  debounce_q  <= pwdata[DEB_BITS-1:0];
				REG_THRESHOLD: threshold_q <= pwdata[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_PERIOD:    prdata = period_q;
			REG_DEBOUNCE:  prdata = APB_DATA_W'(debounce_q);
			REG_THRESHOLD: prdata = APB_DATA_W'(threshold_q);
			default:       prdata = '0;
		endcase
	end

	jsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	jsr_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_now           (s_tdata[TIME_BITS-1:0]),
		.in_x             (s_tdata[TIME_BITS +: SAMPLE_BITS]),
		.in_y             (s_tdata[TIME_BITS+SAMPLE_BITS +: SAMPLE_BITS]),
		.in_button        (s_tdata[IN_USED-1]),
		.period_ms        (period_q),
		.debounce_ms      (debounce_q),
		.change_threshold (threshold_q),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_mean_x       (mean_x),
		.out_mean_y       (mean_y),
		.out_pressed      (pressed)
	);

	assign m_tdata = OUT_W'({pressed, mean_y, mean_x});

endmodule

// File: test/tb.sv
// Self-checking testbench for joystick_smoothing_reporter_unit: stream polls in,
// report beats out, APB register writes between phases. Needs rtl/jsr_pkg.sv and
// the unit itself.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import jsr_pkg::*;

	localparam int unsigned WIN         = DEF_WINDOW_DEPTH;
	localparam int unsigned SBITS       = DEF_SAMPLE_BITS;
	localparam int unsigned MBITS       = SBITS + FRAC_BITS;
	localparam int unsigned IN_W        = ((33 + 2*SBITS + 7)/8)*8;
	localparam int unsigned OUT_W       = ((2*MBITS + 1 + 7)/8)*8;
	localparam int unsigned SETTLE_CYC  = 40;
	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic             pressed;
		logic [MBITS-1:0] mean_y;
		logic [MBITS-1:0] mean_x;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;   // now_ms, x_sample, y_sample, button_raw, zero pad
	logic m_tvalid;
	logic m_tready = 1'b1;
	logic [OUT_W-1:0] m_tdata;       // mean_x, mean_y, pressed, zero pad
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	joystick_smoothing_reporter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// shadow of the unit's registers and filter state
	logic [TIME_BITS-1:0] cfg_period = PERIOD_RST;
	logic [DEB_BITS-1:0]  cfg_debounce = DEBOUNCE_RST;
	logic [THR_BITS-1:0]  cfg_thresh = THRESHOLD_RST;
	logic [SBITS-1:0] x_hist [WIN];
	logic [SBITS-1:0] y_hist [WIN];
	int unsigned slot = 0;
	int unsigned filled = 0;
	logic [31:0] last_poll = '0;
	logic [31:0] last_edge = '0;
	logic prev_raw = 1'b0;
	logic debounced = 1'b0;
	logic have_report = 1'b0;
	logic [MBITS-1:0] shown_x = '0;
	logic [MBITS-1:0] shown_y = '0;

	report_t pending_reports [$];
	logic [31:0] wall_ms = '0;
	bit quiet = 1'b0;
	int errors = 0;
	int unsigned cycles = 0;
	int unsigned stall_left = 0;

	initial begin
		for (int i = 0; i < WIN; i++) begin
			x_hist[i] = '0;
			y_hist[i] = '0;
		end
	end

	function automatic logic [MBITS-1:0] window_mean(input logic [SBITS-1:0] h [WIN],
			input int unsigned n);
		int unsigned acc;
		acc = 0;
		for (int i = 0; i < n; i++)
			acc += h[i];
		return (n == 0) ? '0 : MBITS'((acc << FRAC_BITS) / n);
	endfunction

	function automatic bit drifted(input logic [MBITS-1:0] now_mean,
			input logic [MBITS-1:0] old_mean);
		int d;
		d = (now_mean >= old_mean) ? int'(now_mean) - int'(old_mean)
			: int'(old_mean) - int'(now_mean);
		return d > int'(cfg_thresh) * 256;
	endfunction

	// Advance the shadow filter by one accepted poll; queue a report if one is due.
	task automatic advance_filter(input logic [31:0] t, input logic [SBITS-1:0] xs,
			input logic [SBITS-1:0] ys, input logic b, output bit acted);
		logic [31:0] elapsed;
		logic [31:0] held;
		report_t r;
		elapsed = t - last_poll;
		acted = (elapsed >= cfg_period);
		if (!acted)
			return;
		last_poll = t;
		if (b != prev_raw)
			last_edge = t;
		held = t - last_edge;
		if (held > {16'd0, cfg_debounce})
			debounced = b;
		prev_raw = b;
		x_hist[slot] = xs;
		y_hist[slot] = ys;
		slot = (slot == WIN - 1) ? 0 : slot + 1;
		if (filled < WIN)
			filled++;
		r.mean_x = window_mean(x_hist, filled);
		r.mean_y = window_mean(y_hist, filled);
		r.pressed = debounced;
		if (!have_report || drifted(r.mean_x, shown_x) || drifted(r.mean_y, shown_y)
				|| debounced) begin
			shown_x = r.mean_x;
			shown_y = r.mean_y;
			have_report = 1'b1;
			pending_reports.push_back(r);
		end
	endtask

	// Leaves tvalid as is at the accepting edge; the next call or the caller decides.
	task automatic send_poll(input logic [31:0] t, input logic [SBITS-1:0] xs,
			input logic [SBITS-1:0] ys, input logic b, output bit acted);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {3'b000, b, ys, xs, t};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		advance_filter(t, xs, ys, b, acted);
	endtask

	task automatic poll(input logic [31:0] t, input logic [SBITS-1:0] xs,
			input logic [SBITS-1:0] ys, input logic b);
		bit acted;
		wall_ms = t;
		send_poll(t, xs, ys, b, acted);
	endtask

	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	// A poll that gives no report may still be in flight after the last beat.
	task automatic settle();
		drain_reports();
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic program_reg(input reg_idx_t idx, input logic [31:0] val);
		settle();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PERIOD:    cfg_period = val;
			REG_DEBOUNCE:  cfg_debounce = val[DEB_BITS-1:0];
			REG_THRESHOLD: cfg_thresh = val[THR_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic check_regs();
		logic [31:0] got;
		logic [31:0] want;
		reg_idx_t idx;
		// the last poll beat must not be taken a second time
		s_tvalid <= 1'b0;
		for (int i = 0; i < 3; i++) begin
			idx = reg_idx_t'(i);
			@(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {idx, 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			got = prdata;
			psel <= 1'b0;
			penable <= 1'b0;
			case (idx)
				REG_PERIOD:    want = cfg_period;
				REG_DEBOUNCE:  want = {16'd0, cfg_debounce};
				default:       want = {22'd0, cfg_thresh};
			endcase
			if (got !== want) begin
				$display("%0t: register %s expected %h actual %h", $time, idx.name(), want, got);
				errors++;
			end
		end
	endtask

	task automatic test_register_access();
		check_regs();
		// the spare address swallows writes
		program_reg(REG_UNUSED, $urandom);
		check_regs();
	endtask

	task automatic test_directed_polls();
		poll(32'd50, 10'd0, 10'd0, 1'b0);          // first poll too early, ignored
		poll(32'd100, 10'd1023, 10'd0, 1'b0);      // first acted poll always reports
		poll(32'd150, 10'd1023, 10'd0, 1'b0);
		poll(32'd200, 10'd0, 10'd1023, 1'b0);
		poll(32'd300, 10'd0, 10'd1023, 1'b1);
		poll(32'd400, 10'd0, 10'd1023, 1'b1);      // held past debounce: pressed
		poll(32'd500, 10'd1023, 10'd1023, 1'b0);
		poll(32'd600, 10'd1023, 10'd1023, 1'b0);
		for (int i = 0; i < 6; i++)                // ring fills with one value and wraps
			poll(32'd700 + 32'(i) * 100, 10'd512, 10'd512, 1'b0);
		poll(32'd1300, 10'd562, 10'd512, 1'b0);    // exactly the threshold
		poll(32'd1400, 10'd563, 10'd462, 1'b0);
		poll(32'hFFFF_FFC0, 10'd1, 10'd1022, 1'b0);
		poll(32'h0000_0030, 10'd1022, 10'd1, 1'b0); // time wraps
		poll(32'h0000_0060, 10'd7, 10'd7, 1'b1);
	endtask

	task automatic test_debounce_edges();
		logic [31:0] base;
		logic pattern [10];
		program_reg(REG_PERIOD, 32'd25);
		base = wall_ms + 32'd1000;
		pattern = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
		for (int i = 0; i < 10; i++)
			poll(base + 32'(i) * 25, 10'd300, 10'd700, pattern[i]);
	endtask

	task automatic test_extreme_settings();
		program_reg(REG_PERIOD, 32'd0);
		program_reg(REG_DEBOUNCE, 32'd0);
		program_reg(REG_THRESHOLD, 32'd0);
		// repeated timestamps: every poll acts
		for (int i = 0; i < 6; i++)
			poll(wall_ms + ((i % 3 == 2) ? 32'd1 : 32'd0), 10'($urandom), 10'($urandom),
				1'($urandom));
		program_reg(REG_PERIOD, 32'hFFFF_FFFF);
		program_reg(REG_DEBOUNCE, 32'h0000_FFFF);
		program_reg(REG_THRESHOLD, 32'h0000_03FF);
		for (int i = 0; i < 6; i++) begin
			poll(last_poll + 32'd5, 10'($urandom), 10'($urandom), 1'b1);
			poll(last_poll - 32'd1, 10'($urandom), 10'($urandom), (i >= 2));
		end
		check_regs();
	endtask

	task automatic random_phase(input logic [31:0] per, input logic [15:0] deb,
			input logic [9:0] thr, input int polls, input bit calm);
		int done;
		int unsigned pick;
		logic [31:0] dt;
		logic [SBITS-1:0] cx;
		logic [SBITS-1:0] cy;
		logic btn;
		bit acted;
		bit paused;
		program_reg(REG_PERIOD, per);
		program_reg(REG_DEBOUNCE, {16'd0, deb});
		program_reg(REG_THRESHOLD, {22'd0, thr});
		quiet = calm;
		cx = SBITS'($urandom);
		cy = SBITS'($urandom);
		btn = 1'b0;
		done = 0;
		paused = 1'b0;
		while (done < polls) begin
			pick = $urandom_range(0, 99);
			if (pick < 75)
				dt = per + $urandom_range(0, 40);
			else if (pick < 93)
				dt = (per == 0) ? 32'd0 : $urandom_range(0, per - 1);
			else
				dt = $urandom;
			wall_ms += dt;
			if ($urandom_range(0, 9) == 0)
				cx = SBITS'($urandom);
			else
				cx = cx + 10'($urandom_range(0, 12)) - 10'd6;
			if ($urandom_range(0, 9) == 0)
				cy = SBITS'($urandom);
			else
				cy = cy + 10'($urandom_range(0, 12)) - 10'd6;
			if ($urandom_range(0, 7) == 0)
				btn = ~btn;
			send_poll(wall_ms, cx, cy, btn, acted);
			if (acted)
				done++;
			if (!paused && done == polls / 2) begin
				paused = 1'b1;
				drain_reports();
			end
		end
	endtask

	task automatic test_random_traffic();
		random_phase(32'd100, 16'd50, 10'd10, 120, 1'b0);
		random_phase(32'd0, 16'd0, 10'd0, 120, 1'b0);
		random_phase(32'd7, 16'd20, 10'd2, 120, 1'b1);
		random_phase(32'd1, 16'd1000, 10'd0, 120, 1'b0);
		random_phase(32'd30, 16'd0, 10'd1023, 120, 1'b0);
		random_phase($urandom_range(0, 200), 16'($urandom_range(0, 300)),
			10'($urandom_range(0, 40)), 120, 1'b0);
		quiet = 1'b0;
	endtask

	// result sink: random stall after each taken beat unless quiet, counted only while tvalid is up
	always @(posedge clk) begin : report_sink
		report_t got;
		report_t want;
		int unsigned n;
		if (m_tvalid && m_tready) begin
			got = report_t'(m_tdata[2*MBITS:0]);
			if (pending_reports.size() == 0) begin
				$display("%0t: report beat with nothing expected, actual %h", $time, got);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (got.mean_x !== want.mean_x) begin
					$display("%0t: mean_x expected %h actual %h", $time, want.mean_x, got.mean_x);
					errors++;
				end
				if (got.mean_y !== want.mean_y) begin
					$display("%0t: mean_y expected %h actual %h", $time, want.mean_y, got.mean_y);
					errors++;
				end
				if (got.pressed !== want.pressed) begin
					$display("%0t: pressed expected %b actual %b", $time, want.pressed,
						got.pressed);
					errors++;
				end
			end
			n = quiet ? 0 : $urandom_range(0, 4);
			stall_left <= n;
			m_tready <= (n == 0);
		end else if (!m_tready && m_tvalid) begin
			if (stall_left <= 1) begin
				m_tready <= 1'b1;
				stall_left <= 0;
			end else begin
				stall_left <= stall_left - 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("joystick_smoothing_reporter_unit: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_directed_polls();
		test_debounce_edges();
		test_extreme_settings();
		test_random_traffic();
		settle();
		if (errors == 0)
			$display("joystick_smoothing_reporter_unit: match");
		else
			$display("joystick_smoothing_reporter_unit: mismatch");
		$finish;
	end

endmodule
